// File: src/plm_pkg.sv
// plm_pkg: types and constants for the peer link liveness monitor
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package plm_pkg;

    localparam int NUM_POS    = 4;      // platoon positions one to four
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 7;
    localparam int MISS_W     = 16;
    localparam int POS_W      = 3;
    localparam int MASK_W     = 5;
    localparam int FLAG_W     = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int COUNT_WRAP = 100;    // receive count returns to zero above this

    localparam logic [POS_W-1:0]  RST_PLATOON_SIZE = 3'd1;
    localparam logic [POS_W-1:0]  RST_OWN_POSITION = 3'd1;
    localparam logic [MISS_W-1:0] RST_MISS_BOUND   = 16'd10;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_PLATOON_SIZE = 2'd0;
    localparam logic [1:0] REG_OWN_POSITION = 2'd1;
    localparam logic [1:0] REG_MISS_BOUND   = 2'd2;

    // fault flag bits
    localparam int FLT_ANY = 3;

    typedef struct packed {
        logic               start_phase;
        logic [STAMP_W-1:0] stamp_pos1;
        logic [STAMP_W-1:0] stamp_pos2;
        logic [STAMP_W-1:0] stamp_pos3;
        logic [STAMP_W-1:0] stamp_pos4;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] error_mask;
        logic              leader_link;
        logic              pred_link;
        logic              follower_link;
        logic              leader_fault;
        logic              pred_fault;
        logic              follower_fault;
        logic              any_fault;
        logic              all_heard;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/plm_if.sv
// plm_in_if / plm_out_if: valid-ready channels for ticks and results
// depends on plm_pkg for the payload types
`default_nettype none

interface plm_in_if;
    import plm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plm_out_if;
    import plm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/peer_link_liveness_monitor.sv
// peer_link_liveness_monitor: top level, per-peer liveness state and fault flags
// depends on plm_pkg and the channel interfaces in plm_if.sv
// a tick is taken into the input register, then its result is written to the result register
//   (input register, then result register); one tick can be accepted every cycle while o_out.ready does not stall
// a single update pass lies between the two registers
// reset (synchronous, active low): link, count and fault state cleared, report
//   armed, registers back to size one, own position one, miss bound ten
`default_nettype none

module peer_link_liveness_monitor (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    plm_in_if.sink                         i_in,
    plm_out_if.source                      o_out,
    input  wire logic                      i_psel,
    input  wire logic                      i_penable,
    input  wire logic                      i_pwrite,
    input  wire logic [plm_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [plm_pkg::DATA_W-1:0] i_pwdata,
    output logic      [plm_pkg::DATA_W-1:0] o_prdata,
    output logic                           o_pready
);
    import plm_pkg::*;

    // configuration registers
    logic [POS_W-1:0]  r_platoon_size;
    logic [POS_W-1:0]  r_own_position;
    logic [MISS_W-1:0] r_miss_bound;

    // pipeline: input register then result register
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      w_advance;

    // per-peer state, index i is position i+1
    logic [STAMP_W-1:0] r_last_stamp  [NUM_POS];
    logic [CNT_W-1:0]   r_rx_count    [NUM_POS];
    logic [CNT_W-1:0]   r_rx_seen     [NUM_POS];
    logic [MISS_W-1:0]  r_miss_count  [NUM_POS];
    logic [NUM_POS-1:0] r_link_up;
    logic               r_report_armed;
    logic               r_heard_prev;
    logic [FLAG_W-1:0]  r_fault_flags;

    logic [STAMP_W-1:0] n_last_stamp  [NUM_POS];
    logic [CNT_W-1:0]   n_rx_count    [NUM_POS];
    logic [CNT_W-1:0]   n_rx_seen     [NUM_POS];
    logic [MISS_W-1:0]  n_miss_count  [NUM_POS];
    logic [NUM_POS-1:0] n_link_up;
    logic               n_report_armed;
    logic               n_heard_prev;
    logic [FLAG_W-1:0]  n_fault_flags;

    logic [STAMP_W-1:0] w_stamp [NUM_POS];
    logic [POS_W-1:0]   w_size;

    // ---------------------------------------------------------------
    // APB configuration port, no wait states
    // ---------------------------------------------------------------
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_platoon_size <= RST_PLATOON_SIZE;
            r_own_position <= RST_OWN_POSITION;
            r_miss_bound   <= RST_MISS_BOUND;
        end else if (i_psel && i_penable && i_pwrite && o_pready) begin
            case (i_paddr[3:2])
                REG_PLATOON_SIZE: r_platoon_size <= i_pwdata[POS_W-1:0];
                REG_OWN_POSITION: r_own_position <= i_pwdata[POS_W-1:0];
                REG_MISS_BOUND:   r_miss_bound   <= i_pwdata[MISS_W-1:0];
                default:          ; // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_PLATOON_SIZE: o_prdata = {{(DATA_W-POS_W){1'b0}}, r_platoon_size};
            REG_OWN_POSITION: o_prdata = {{(DATA_W-POS_W){1'b0}}, r_own_position};
            REG_MISS_BOUND:   o_prdata = {{(DATA_W-MISS_W){1'b0}}, r_miss_bound};
            default:          o_prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: the input register moves on whenever the result register
    // is empty or its transfer completes this cycle
    // ---------------------------------------------------------------
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    // ---------------------------------------------------------------
    // tick update
    // ---------------------------------------------------------------
    assign w_stamp[0] = r_in_item.stamp_pos1;
    assign w_stamp[1] = r_in_item.stamp_pos2;
    assign w_stamp[2] = r_in_item.stamp_pos3;
    assign w_stamp[3] = r_in_item.stamp_pos4;

    // platoon size zero counts as one, five to seven as four
    always_comb begin
        if (r_platoon_size == 3'd0) begin
            w_size = 3'd1;
        end else if (r_platoon_size > 3'(NUM_POS)) begin
            w_size = 3'(NUM_POS);
        end else begin
            w_size = r_platoon_size;
        end
    end

    always_comb begin
        logic [CNT_W:0]    v_cnt;
        logic [MISS_W-1:0] v_miss;
        logic              v_armed;
        logic [POS_W-1:0]  v_heard;
        logic [MASK_W-1:0] v_error;
        logic [2:0]        v_links;
        logic              v_all;

        n_last_stamp   = r_last_stamp;
        n_rx_count     = r_rx_count;
        n_rx_seen      = r_rx_seen;
        n_miss_count   = r_miss_count;
        n_link_up      = r_link_up;
        n_fault_flags  = r_fault_flags;
        v_armed        = r_report_armed;
        v_heard        = '0;
        v_error        = '0;
        v_links        = 3'b111;
        v_all          = 1'b1;
        v_cnt          = '0;
        v_miss         = '0;

        if (w_size == 3'd1) begin
            // single vehicle: nothing to watch, everything reads healthy
            n_link_up[0]  = 1'b1;
            n_fault_flags = '0;
        end else begin
            for (int i = 0; i < NUM_POS; i++) begin
                if (3'(i + 1) <= w_size) begin
                    if (r_in_item.start_phase) begin
                        n_link_up[i] = 1'b0;
                    end
                    if (3'(i + 1) != r_own_position) begin
                        if (w_stamp[i] != r_last_stamp[i]) begin
                            // fresh timestamp: advance the wrapping receive count
                            v_cnt = {1'b0, r_rx_count[i]} + 1'b1;
                            if (v_cnt > (CNT_W + 1)'(COUNT_WRAP)) begin
                                v_cnt = '0;
                            end
                            n_rx_count[i]   = v_cnt[CNT_W-1:0];
                            n_last_stamp[i] = w_stamp[i];
                            v_heard         = v_heard + 1'b1;
                        end else begin
                            // stale timestamp: count a miss, saturating
                            v_miss = r_miss_count[i];
                            if (v_miss != '1) begin
                                v_miss = v_miss + 1'b1;
                            end
                            n_miss_count[i] = v_miss;
                            // first lost link of the run gets reported, lowest position first
                            if (v_miss > r_miss_bound && v_armed && n_link_up[i]) begin
                                n_link_up[i]   = 1'b0;
                                v_armed        = 1'b0;
                                v_error[i + 1] = 1'b1;
                            end
                        end
                        if (n_rx_count[i] != r_rx_seen[i]) begin
                            n_link_up[i]    = 1'b1;
                            n_miss_count[i] = '0;
                            n_rx_seen[i]    = n_rx_count[i];
                        end else begin
                            n_link_up[i] = 1'b0;
                        end
                    end
                end
            end

            // leader, predecessor and follower fault flags; any stays set until reset or a platoon size of one
            for (int i = 0; i < 3; i++) begin
                if (n_link_up[i]) begin
                    n_fault_flags[i] = 1'b0;
                end else if (n_miss_count[i] > r_miss_bound && r_heard_prev) begin
                    n_fault_flags[i]       = 1'b1;
                    n_fault_flags[FLT_ANY] = 1'b1;
                end
            end

            v_links = n_link_up[2:0];
            v_all   = (v_heard == w_size - 1'b1);
        end

        n_report_armed = v_armed;
        n_heard_prev   = v_all;

        n_out_item.error_mask     = v_error;
        n_out_item.leader_link    = v_links[0];
        n_out_item.pred_link      = v_links[1];
        n_out_item.follower_link  = v_links[2];
        n_out_item.leader_fault   = n_fault_flags[0];
        n_out_item.pred_fault     = n_fault_flags[1];
        n_out_item.follower_fault = n_fault_flags[2];
        n_out_item.any_fault      = n_fault_flags[FLT_ANY];
        n_out_item.all_heard      = v_all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POS; i++) begin
                r_last_stamp[i] <= '0;
                r_rx_count[i]   <= '0;
                r_rx_seen[i]    <= '0;
                r_miss_count[i] <= '0;
            end
            r_link_up      <= '0;
            r_report_armed <= 1'b1;
            r_heard_prev   <= 1'b0;
            r_fault_flags  <= '0;
        end else if (w_advance) begin
            r_last_stamp   <= n_last_stamp;
            r_rx_count     <= n_rx_count;
            r_rx_seen      <= n_rx_seen;
            r_miss_count   <= n_miss_count;
            r_link_up      <= n_link_up;
            r_report_armed <= n_report_armed;
            r_heard_prev   <= n_heard_prev;
            r_fault_flags  <= n_fault_flags;
        end
    end

endmodule

`default_nettype wire
